// File: rtl/core/adee_pkg.sv
// ----------------------------------------------------------------------------
// adee_pkg
// Shared types and constants for the asymmetric debounce / edge detect unit.
// ----------------------------------------------------------------------------
package adee_pkg;

   localparam int STAMP_W   = 32;
   localparam int TIME_W    = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [TIME_W-1:0] ON_TIME_RESET  = 16'd100;
   localparam logic [TIME_W-1:0] OFF_TIME_RESET = 16'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ON_TIME  = 1'b0,
      CSR_OFF_TIME = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      CODE_LOW     = 2'd0,
      CODE_HIGH    = 2'd1,
      CODE_RISING  = 2'd2,
      CODE_FALLING = 2'd3
   } level_code_type;

   // thresholds handed from the register block to the tracker
   typedef struct packed {
      logic [TIME_W-1:0] on_time;
      logic [TIME_W-1:0] off_eff;
   } thresh_type;

endpackage

// File: rtl/core/asymmetric_debounce_edge_detect_unit.sv
// ----------------------------------------------------------------------------
// asymmetric_debounce_edge_detect_unit
// Time-based switch debouncer with separate rise and fall persistence times.
// ----------------------------------------------------------------------------
// Each item carries a raw switch sample and a free-running millisecond stamp;
// each item returns exactly one code: low, high, rising or falling. The level
// rises once the sample has been high for more than on_time ms since it was
// last seen low, and falls once it has been low for more than off_time ms
// (on_time when off_time is 0) since it was last seen high. Durations are
// wrapping 32-bit differences. An accepted item passes the input register,
// then the result register, where a receiver stall can hold it; throughput
// is one item per clock while rsp_ready is not held low, with the tracker's
// single subtract/compare path between the two registers. Configuration
// is to be written by the user only while no item is in flight; unenforced.
// ----------------------------------------------------------------------------
module asymmetric_debounce_edge_detect_unit (
   input  logic                              clock,
   input  logic                              reset,
   // input items
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_sample,
   input  logic [adee_pkg::STAMP_W-1:0]      req_now_ms,
   // result items
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_level_code,
   // configuration
   input  logic                              csr_write,
   input  logic [adee_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [adee_pkg::TIME_W-1:0]       csr_wdata
);

   adee_pkg::thresh_type         thresh;
   adee_pkg::level_code_type     code;

   // input stage
   logic                         in_vld_ff;
   logic                         in_vld_in;
   logic                         in_sample_ff;
   logic [adee_pkg::STAMP_W-1:0] in_now_ff;
   // result stage
   logic                         out_vld_ff;
   logic                         out_vld_in;
   logic [1:0]                   out_code_ff;

   logic                         req_take;
   logic                         advance;

   // item moves into the result register when that slot is free or draining
   assign advance   = in_vld_ff & (~out_vld_ff | rsp_ready);
   assign req_ready = ~in_vld_ff | advance;
   assign req_take  = req_valid & req_ready;

   assign in_vld_in  = req_take | (in_vld_ff & ~advance);
   assign out_vld_in = advance | (out_vld_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_ff <= req_sample;
         in_now_ff    <= req_now_ms;
      end
      if (advance) begin
         out_code_ff <= code;
      end
   end

   adee_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .thresh    (thresh)
   );

   // state commits on the same edge the code is captured
   adee_tracker u_tracker (
      .clock  (clock),
      .reset  (reset),
      .update (advance),
      .sample (in_sample_ff),
      .now_ms (in_now_ff),
      .thresh (thresh),
      .code   (code)
   );

   assign rsp_valid      = out_vld_ff;
   assign rsp_level_code = out_code_ff;

   // a held input item is never dropped
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff)
      else $error("input item lost while stalled");

   // every advance yields a result
   a_adv_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_vld_ff)
      else $error("advanced item produced no result");

   // an accepted item lands in the input register
   a_take_in: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_vld_ff)
      else $error("accepted item not registered");

   // empty input stage is always ready to take an item
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !in_vld_ff |-> req_ready)
      else $error("empty input stage not ready");

endmodule

// File: rtl/core/adee_csr.sv
// ----------------------------------------------------------------------------
// adee_csr
// Configuration registers; resolves the effective off time.
// ----------------------------------------------------------------------------
module adee_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [adee_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [adee_pkg::TIME_W-1:0]       csr_wdata,
   output adee_pkg::thresh_type              thresh
);

   logic [adee_pkg::TIME_W-1:0] on_time_ff;
   logic [adee_pkg::TIME_W-1:0] off_time_ff;
   logic [adee_pkg::TIME_W-1:0] on_time_in;
   logic [adee_pkg::TIME_W-1:0] off_time_in;

   always_comb begin
      on_time_in  = on_time_ff;
      off_time_in = off_time_ff;
      if (csr_write) begin
         unique case (adee_pkg::csr_index_type'(csr_index))
            adee_pkg::CSR_ON_TIME:  on_time_in  = csr_wdata;
            adee_pkg::CSR_OFF_TIME: off_time_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_time_ff  <= adee_pkg::ON_TIME_RESET;
         off_time_ff <= adee_pkg::OFF_TIME_RESET;
      end else begin
         on_time_ff  <= on_time_in;
         off_time_ff <= off_time_in;
      end
   end

   // zero off time falls back to on time
   assign thresh.on_time = on_time_ff;
   assign thresh.off_eff = (off_time_ff == '0) ? on_time_ff : off_time_ff;

endmodule

// File: rtl/core/adee_tracker.sv
// ----------------------------------------------------------------------------
// adee_tracker
// Timestamp and debounced level state; classifies one item per update.
// ----------------------------------------------------------------------------
module adee_tracker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              update,
   input  logic                              sample,
   input  logic [adee_pkg::STAMP_W-1:0]      now_ms,
   input  adee_pkg::thresh_type              thresh,
   output adee_pkg::level_code_type          code
);

   logic [adee_pkg::STAMP_W-1:0] low_stamp_ff;
   logic [adee_pkg::STAMP_W-1:0] high_stamp_ff;
   logic                         level_ff;
   logic [adee_pkg::STAMP_W-1:0] low_stamp_in;
   logic [adee_pkg::STAMP_W-1:0] high_stamp_in;
   logic                         level_in;
   logic [adee_pkg::STAMP_W-1:0] dur;
   logic                         over;
   logic                         level_new;

   // only one duration is computed per item: pick the opposite stamp
   always_comb begin
      dur = now_ms - (sample ? low_stamp_ff : high_stamp_ff);
      if (sample) begin
         over = dur > {{(adee_pkg::STAMP_W-adee_pkg::TIME_W){1'b0}}, thresh.on_time};
      end else begin
         over = dur > {{(adee_pkg::STAMP_W-adee_pkg::TIME_W){1'b0}}, thresh.off_eff};
      end
      level_new = sample ? (level_ff | over) : (level_ff & ~over);

      if (!level_ff && level_new)      code = adee_pkg::CODE_RISING;
      else if (level_ff && !level_new) code = adee_pkg::CODE_FALLING;
      else if (level_new)              code = adee_pkg::CODE_HIGH;
      else                             code = adee_pkg::CODE_LOW;

      low_stamp_in  = low_stamp_ff;
      high_stamp_in = high_stamp_ff;
      level_in      = level_ff;
      if (update) begin
         level_in = level_new;
         if (sample) high_stamp_in = now_ms;
         else        low_stamp_in  = now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_stamp_ff  <= '0;
         high_stamp_ff <= '0;
         level_ff      <= 1'b0;
      end else begin
         low_stamp_ff  <= low_stamp_in;
         high_stamp_ff <= high_stamp_in;
         level_ff      <= level_in;
      end
   end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the asymmetric debounce / edge detect unit.
// ----------------------------------------------------------------------------
// A behavioral debouncer tracks the two last-seen stamps and the debounced
// level. It predicts one level code per accepted item, and a monitor checks
// every result against the oldest pending code. Named tests run in turn:
// directed threshold and wrap cases, a long receiver stall that backs the
// block up, and randomized bouncy-switch sessions over several thresholds.
// ----------------------------------------------------------------------------
module tb;

   localparam int QUIET_LIMIT = 2000;   // cycles with no handshake at all
   localparam int STALL_HOLD  = 300;    // long receiver hold-off
   localparam int DRAIN_WAIT  = 8;      // pipeline is two deep

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic                           req_sample = 1'b0;
   logic [adee_pkg::STAMP_W-1:0]   req_now_ms = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [1:0]                     rsp_level_code;
   logic                           csr_write = 1'b0;
   logic [adee_pkg::CSR_IDX_W-1:0] csr_index = adee_pkg::CSR_ON_TIME;
   logic [adee_pkg::TIME_W-1:0]    csr_wdata = '0;

   asymmetric_debounce_edge_detect_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_now_ms     (req_now_ms),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_level_code (rsp_level_code),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Debouncer shadow: thresholds as last written, stamps and level as the
   // block should hold them after every accepted item.
   // ------------------------------------------------------------------------
   logic [adee_pkg::TIME_W-1:0]  cfg_on  = adee_pkg::ON_TIME_RESET;
   logic [adee_pkg::TIME_W-1:0]  cfg_off = adee_pkg::OFF_TIME_RESET;
   logic [adee_pkg::STAMP_W-1:0] last_low_ms  = '0;
   logic [adee_pkg::STAMP_W-1:0] last_high_ms = '0;
   bit                           sw_level = 1'b0;

   adee_pkg::level_code_type pending_codes[$];
   int                       err_count = 0;

   // idle knobs, flipped per test
   bit sender_idle   = 1'b1;
   bit receiver_idle = 1'b1;
   bit stall_request = 1'b0;

   function automatic adee_pkg::level_code_type predict_level(
      bit s, logic [adee_pkg::STAMP_W-1:0] t);
      logic [adee_pkg::STAMP_W-1:0] high_run;
      logic [adee_pkg::STAMP_W-1:0] low_run;
      logic [adee_pkg::STAMP_W-1:0] off_eff;
      bit                           was_high;
      high_run = '0;
      low_run  = '0;
      // zero off time falls back to the on time
      off_eff  = (cfg_off == '0) ? adee_pkg::STAMP_W'(cfg_on)
                                 : adee_pkg::STAMP_W'(cfg_off);
      was_high = sw_level;
      if (s) begin
         high_run     = t - last_low_ms;    // wraps mod 2^32
         last_high_ms = t;
      end else begin
         low_run     = t - last_high_ms;
         last_low_ms = t;
      end
      if (high_run > adee_pkg::STAMP_W'(cfg_on)) sw_level = 1'b1;
      if (low_run > off_eff)                     sw_level = 1'b0;
      if (!was_high && sw_level)      return adee_pkg::CODE_RISING;
      else if (was_high && !sw_level) return adee_pkg::CODE_FALLING;
      else if (sw_level)              return adee_pkg::CODE_HIGH;
      else                            return adee_pkg::CODE_LOW;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)      return $urandom_range(1, 3);
      else if (r < 95) return $urandom_range(4, 10);
      else             return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      err_count++;
   endtask

   // ------------------------------------------------------------------------
   // Sender: one item per call. Valid stays up across back-to-back items and
   // only drops when a gap is inserted, so it is never lowered and raised in
   // the same step. Prediction happens at the accepting edge.
   // ------------------------------------------------------------------------
   task automatic send_item(bit s, logic [adee_pkg::STAMP_W-1:0] t);
      int gap;
      gap = (sender_idle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      req_now_ms <= t;
      do @(posedge clock); while (!(req_valid && req_ready));
      pending_codes.push_back(predict_level(s, t));
   endtask

   // Thresholds change only with nothing in flight: every item yields a
   // result, so an empty queue means idle.
   task automatic set_thresholds(logic [adee_pkg::TIME_W-1:0] on_ms,
                                 logic [adee_pkg::TIME_W-1:0] off_ms);
      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= adee_pkg::CSR_ON_TIME;
      csr_wdata <= on_ms;
      @(posedge clock);
      csr_index <= adee_pkg::CSR_OFF_TIME;
      csr_wdata <= off_ms;
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_on  = on_ms;
      cfg_off = off_ms;
   endtask

   // ------------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off on request. The hold-off
   // is counted here so the sender keeps offering items meanwhile.
   // ------------------------------------------------------------------------
   int hold_left  = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      if (stall_request) begin
         stall_request <= 1'b0;
         hold_left     <= STALL_HOLD;
         rsp_ready     <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!receiver_idle || reset) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left <= pick_gap() - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // result monitor: oldest pending code first
   always @(posedge clock) begin
      adee_pkg::level_code_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_codes.size() == 0) begin
            report_mismatch($sformatf("result code %0d with no item pending",
                                      rsp_level_code));
         end else begin
            want = pending_codes.pop_front();
            if (rsp_level_code !== want)
               report_mismatch($sformatf("level_code got %0d want %0d (%s)",
                                         rsp_level_code, want, want.name()));
         end
      end
   end

   // watchdog: too long without any handshake means a hang
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // reset thresholds: on 100, off falls back to on; stamp wrap at 2^32 and
   // stamps that run backwards
   task automatic test_default_thresholds();
      send_item(1'b1, 32'd0);           // duration 0 from the reset stamp
      send_item(1'b1, 32'd100);         // exactly on_time: no rise yet
      send_item(1'b1, 32'd101);         // one past: rising
      send_item(1'b1, 32'hFFFF_FFFF);
      send_item(1'b0, 32'hFFFF_FFFF);   // low run 0
      send_item(1'b0, 32'd99);          // wraps to exactly 100
      send_item(1'b0, 32'd100);         // wraps to 101: falling
      send_item(1'b1, 32'd50);          // backwards stamp, huge high run
   endtask

   // zero on time: any positive duration flips the level both ways
   task automatic test_zero_on_time();
      set_thresholds(16'd0, 16'd0);
      send_item(1'b0, 32'd1000);
      send_item(1'b1, 32'd1000);
      send_item(1'b1, 32'd1001);
      send_item(1'b0, 32'd1001);
      send_item(1'b0, 32'd1002);
   endtask

   // widest thresholds, right at the boundary
   task automatic test_max_thresholds();
      set_thresholds(16'hFFFF, 16'hFFFF);
      send_item(1'b0, 32'h8000_0000);
      send_item(1'b1, 32'h8000_0000 + 32'd65535);
      send_item(1'b1, 32'h8000_0000 + 32'd65536);
      send_item(1'b0, 32'h8000_0000 + 32'd131071);
      send_item(1'b0, 32'h8000_0000 + 32'd131072);
   endtask

   // distinct rise and fall times, each way round
   task automatic test_asymmetric();
      set_thresholds(16'd3, 16'd40);
      send_item(1'b1, 32'h0001_0000);
      send_item(1'b1, 32'h0001_0004);
      send_item(1'b0, 32'h0001_002C);   // low run 40: holds
      send_item(1'b0, 32'h0001_002D);   // low run 41: falls
      set_thresholds(16'd2000, 16'd1);
      send_item(1'b1, 32'h0001_0900);
      send_item(1'b0, 32'h0001_0902);
   endtask

   // hold the receiver off while the sender streams, so the block fills
   // and drops req_ready
   task automatic test_fill_and_stall();
      sender_idle    = 1'b0;
      stall_request <= 1'b1;
      for (int i = 0; i < 40; i++)
         send_item(1'($urandom_range(0, 1)), $urandom);
      sender_idle = 1'b1;
   endtask

   // One session of a bouncing switch: bursts of fast toggles, then stable
   // runs long enough to cross the thresholds, with stray items mixed in.
   task automatic drive_switch_session(int count);
      logic [adee_pkg::STAMP_W-1:0] t;
      int unsigned                  span;
      int unsigned                  off_eff;
      int                           done;
      int                           run;
      bit                           lvl;
      t       = $urandom;
      off_eff = (cfg_off == '0) ? 32'(cfg_on) : 32'(cfg_off);
      span    = (32'(cfg_on) > off_eff) ? 32'(cfg_on) : off_eff;
      done    = 0;
      while (done < count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(1'($urandom_range(0, 1)), $urandom);
            done++;
         end
         run = $urandom_range(1, 6);
         for (int i = 0; i < run; i++) begin
            send_item(1'($urandom_range(0, 1)), t);
            t = t + $urandom_range(0, span / 8 + 1);
         end
         done += run;
         lvl = 1'($urandom_range(0, 1));
         run = $urandom_range(2, 8);
         for (int i = 0; i < run; i++) begin
            t = t + $urandom_range(0, span / 2 + 2);
            send_item(lvl, t);
         end
         done += run;
      end
   endtask

   function automatic logic [adee_pkg::TIME_W-1:0] pick_threshold();
      case ($urandom_range(0, 6))
         0:       return '0;
         1:       return '1;
         2, 3:    return adee_pkg::TIME_W'($urandom_range(1, 20));
         4:       return adee_pkg::TIME_W'($urandom_range(21, 1000));
         default: return adee_pkg::TIME_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic test_random_sessions();
      logic [adee_pkg::TIME_W-1:0] on_ms;
      logic [adee_pkg::TIME_W-1:0] off_ms;
      for (int phase = 0; phase < 7; phase++) begin
         on_ms  = pick_threshold();
         off_ms = ($urandom_range(0, 2) == 0) ? '0 : pick_threshold();
         set_thresholds(on_ms, off_ms);
         sender_idle   = ($urandom_range(0, 2) != 0);
         receiver_idle = ($urandom_range(0, 2) != 0);
         drive_switch_session(145);
      end
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_thresholds();
      test_zero_on_time();
      test_max_thresholds();
      test_asymmetric();
      test_fill_and_stall();
      test_random_sessions();

      // drain, then let the pipeline settle; the watchdog covers a hang
      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: files.f
rtl/core/adee_pkg.sv
rtl/core/adee_csr.sv
rtl/core/adee_tracker.sv
rtl/core/asymmetric_debounce_edge_detect_unit.sv
tb/tb.sv
